/* sv/lrfs_pkg.sv */
// Shared types, widths, operation codes and the finishing program of the regression core.
`default_nettype none

package lrfs_pkg;

  // Field widths of the ports.
  localparam int TraitW  = 24;
  localparam int CodeW   = 4;
  localparam int MarkW   = 18;
  localparam int CoefW   = 32;
  localparam int FstatW  = 48;
  localparam int SampW   = 13;

  // Accumulator widths.
  localparam int SyW     = 36;
  localparam int SyyW    = 60;
  localparam int SxW     = 30;
  localparam int SxxW    = 48;
  localparam int SxyW    = 54;

  // Width of the exact arithmetic used when a batch closes.
  localparam int BigW    = 176;
  localparam int LoopW   = $clog2(BigW);
  localparam int RegN    = 16;
  localparam int RegAW   = $clog2(RegN);
  localparam int ImmW    = 5;
  localparam int PcW     = 6;
  localparam logic [PcW-1:0] ProgLast = PcW'(39);

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    OP_LDA,
    OP_LDI,
    OP_SUB,
    OP_SHL,
    OP_MUL,
    OP_DIV,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [RegAW-1:0] dst;
    logic [RegAW-1:0] a;
    logic [RegAW-1:0] b;
    logic [ImmW-1:0]  imm;
  } instr_t;

  // Accumulator selects for a load.
  localparam logic [ImmW-1:0] ACC_N   = 5'd0;
  localparam logic [ImmW-1:0] ACC_SY  = 5'd1;
  localparam logic [ImmW-1:0] ACC_SX  = 5'd2;
  localparam logic [ImmW-1:0] ACC_SXX = 5'd3;
  localparam logic [ImmW-1:0] ACC_SXY = 5'd4;
  localparam logic [ImmW-1:0] ACC_SYY = 5'd5;

  // Result captures.
  localparam logic [ImmW-1:0] OUT_B1  = 5'd0;
  localparam logic [ImmW-1:0] OUT_B0  = 5'd1;
  localparam logic [ImmW-1:0] OUT_B0N = 5'd2;
  localparam logic [ImmW-1:0] OUT_F   = 5'd3;
  localparam logic [ImmW-1:0] OUT_SXX = 5'd4;
  localparam logic [ImmW-1:0] OUT_SYY = 5'd5;
  localparam logic [ImmW-1:0] OUT_DEN = 5'd6;

  function automatic instr_t mk(input op_e op, input int d, input int a, input int b,
                                input logic [ImmW-1:0] imm);
    instr_t r;
    r.op  = op;
    r.dst = RegAW'(d);
    r.a   = RegAW'(a);
    r.b   = RegAW'(b);
    r.imm = imm;
    return r;
  endfunction

  // Finishing program. Register use: 0 n, 1 Sy, 2 Sx, 3 Sxx, 4 Sxy, 5 Syy,
  // 6 n*Sxx', 7 n*Sxy', 8 n*Syy', 9 slope, 10 intercept, 11 plain mean,
  // 12 denominator of F, 13 F, 14 n-2.
  function automatic instr_t lrfs_prog(input logic [PcW-1:0] pc);
    instr_t r;
    case (pc)
      6'd0:  r = mk(OP_LDA, 0, 0, 0, ACC_N);
      6'd1:  r = mk(OP_LDA, 1, 0, 0, ACC_SY);
      6'd2:  r = mk(OP_LDA, 2, 0, 0, ACC_SX);
      6'd3:  r = mk(OP_LDA, 3, 0, 0, ACC_SXX);
      6'd4:  r = mk(OP_LDA, 4, 0, 0, ACC_SXY);
      6'd5:  r = mk(OP_LDA, 5, 0, 0, ACC_SYY);
      6'd6:  r = mk(OP_MUL, 6, 0, 3, 5'd0);
      6'd7:  r = mk(OP_MUL, 7, 2, 2, 5'd0);
      6'd8:  r = mk(OP_SUB, 6, 6, 7, 5'd0);
      6'd9:  r = mk(OP_MUL, 7, 0, 4, 5'd0);
      6'd10: r = mk(OP_MUL, 8, 2, 1, 5'd0);
      6'd11: r = mk(OP_SUB, 7, 7, 8, 5'd0);
      6'd12: r = mk(OP_MUL, 8, 0, 5, 5'd0);
      6'd13: r = mk(OP_MUL, 9, 1, 1, 5'd0);
      6'd14: r = mk(OP_SUB, 8, 8, 9, 5'd0);
      6'd15: r = mk(OP_SHL, 9, 7, 0, 5'd20);
      6'd16: r = mk(OP_DIV, 9, 9, 6, 5'd0);
      6'd17: r = mk(OP_MUL, 10, 1, 6, 5'd0);
      6'd18: r = mk(OP_MUL, 11, 7, 2, 5'd0);
      6'd19: r = mk(OP_SUB, 10, 10, 11, 5'd0);
      6'd20: r = mk(OP_SHL, 10, 10, 0, 5'd4);
      6'd21: r = mk(OP_MUL, 11, 0, 6, 5'd0);
      6'd22: r = mk(OP_DIV, 10, 10, 11, 5'd0);
      6'd23: r = mk(OP_SHL, 11, 1, 0, 5'd4);
      6'd24: r = mk(OP_DIV, 11, 11, 0, 5'd0);
      6'd25: r = mk(OP_MUL, 12, 6, 8, 5'd0);
      6'd26: r = mk(OP_MUL, 13, 7, 7, 5'd0);
      6'd27: r = mk(OP_SUB, 12, 12, 13, 5'd0);
      6'd28: r = mk(OP_LDI, 14, 0, 0, 5'd2);
      6'd29: r = mk(OP_SUB, 14, 0, 14, 5'd0);
      6'd30: r = mk(OP_MUL, 13, 13, 14, 5'd0);
      6'd31: r = mk(OP_SHL, 13, 13, 0, 5'd16);
      6'd32: r = mk(OP_DIV, 13, 13, 12, 5'd0);
      6'd33: r = mk(OP_OUT, 0, 9, 0, OUT_B1);
      6'd34: r = mk(OP_OUT, 0, 10, 0, OUT_B0);
      6'd35: r = mk(OP_OUT, 0, 11, 0, OUT_B0N);
      6'd36: r = mk(OP_OUT, 0, 13, 0, OUT_F);
      6'd37: r = mk(OP_OUT, 0, 6, 0, OUT_SXX);
      6'd38: r = mk(OP_OUT, 0, 8, 0, OUT_SYY);
      6'd39: r = mk(OP_OUT, 0, 12, 0, OUT_DEN);
      default: r = mk(OP_LDI, 15, 0, 0, 5'd0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/linear_regression_f_stat_core.sv */
// Top level: simple linear regression of a trait on a marker with an F test.
`default_nettype none

// Input words carry one individual each: trait, genotype code, imputed marker
// value and a last flag. The input channel is stalled while a word is being
// worked on. Every word is first taken into registers, then three products
// go one a cycle through a shared 24 x 24 multiplier into the sums.
// The word marked last then starts a finishing program of 40 steps on one
// shared 177-bit add/subtract unit and a 16-entry register memory: products
// go one bit a cycle by shift and add, and each of the four divisions runs
// bit by bit through the full 176-bit width of the exact arithmetic.
// The result word (intercept, slope, F, flags, count) is held in an output
// register until the receiver lifts its stall; while it waits the next
// batch is taken as usual, and the next result waits until the register is
// free. The threshold register may be written at any time the block is idle
// and is always ready. Reset clears the sums, the count, the output valid
// and sets the threshold to its lowest value.
module linear_regression_f_stat_core #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic signed [lrfs_pkg::TraitW-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lrfs_pkg::TraitW-1:0]  trait_value_i,
  input  logic signed [lrfs_pkg::CodeW-1:0]   marker_code_i,
  input  logic signed [lrfs_pkg::MarkW-1:0]   imputed_marker_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lrfs_pkg::CoefW-1:0]   intercept_o,
  output logic signed [lrfs_pkg::CoefW-1:0]   slope_o,
  output logic        [lrfs_pkg::FstatW-1:0]  f_statistic_o,
  output logic                                slope_undefined_o,
  output logic                                f_undefined_o,
  output logic        [lrfs_pkg::SampW-1:0]   samples_used_o
);
  import lrfs_pkg::*;

  localparam int CntW = $clog2(MAX_SAMPLES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M1    = 4'd1;
  localparam logic [3:0] S_M2    = 4'd2;
  localparam logic [3:0] S_M3    = 4'd3;
  localparam logic [3:0] S_M4    = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_OP    = 4'd6;
  localparam logic [3:0] S_ABSA  = 4'd7;
  localparam logic [3:0] S_ABSB  = 4'd8;
  localparam logic [3:0] S_LOOP  = 4'd9;
  localparam logic [3:0] S_FIX   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // Saturate a wide signed value to 32 bits.
  function automatic logic [CoefW-1:0] sat_s32(input logic [BigW-1:0] v);
    logic [CoefW-1:0] r;
    if ((&v[BigW-1:CoefW-1]) || !(|v[BigW-1:CoefW-1])) begin
      r = v[CoefW-1:0];
    end else if (v[BigW-1]) begin
      r = {1'b1, {(CoefW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoefW-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp a wide signed value into the unsigned 48-bit range.
  function automatic logic [FstatW-1:0] sat_u48(input logic [BigW-1:0] v);
    logic [FstatW-1:0] r;
    if (v[BigW-1]) begin
      r = '0;
    end else if (|v[BigW-1:FstatW]) begin
      r = '1;
    end else begin
      r = v[FstatW-1:0];
    end
    return r;
  endfunction

  // Control state.
  logic [3:0]               state_q, state_d;
  logic signed [TraitW-1:0] thr_q, thr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic signed [SyW-1:0]    acc_y_q, acc_y_d;
  logic signed [SyyW-1:0]   acc_yy_q, acc_yy_d;
  logic signed [SxW-1:0]    acc_x_q, acc_x_d;
  logic signed [SxxW-1:0]   acc_xx_q, acc_xx_d;
  logic signed [SxyW-1:0]   acc_xy_q, acc_xy_d;
  logic [PcW-1:0]           pc_q, pc_d;
  logic                     ov_q, ov_d;

  // Datapath registers.
  logic signed [TraitW-1:0]   y_q, y_d;
  logic signed [MarkW-1:0]    x_q, x_d;
  logic                       last_q, last_d;
  logic                       use_q, use_d;
  logic signed [2*TraitW-1:0] p_q, p_d;
  instr_t                     ins_q, ins_d;
  logic [BigW-1:0]            rda_q, rdb_q;
  logic [BigW-1:0]            acc_q, acc_d, m_q, m_d, qr_q, qr_d;
  logic                       neg_q, neg_d, dz_q, dz_d;
  logic [LoopW-1:0]           lc_q, lc_d;
  logic [CoefW-1:0]           b1h_q, b1h_d, b0h_q, b0h_d, b0nh_q, b0nh_d;
  logic [FstatW-1:0]          fh_q, fh_d;
  logic                       sxxbad_q, sxxbad_d, syyz_q, syyz_d, dpos_q, dpos_d;
  logic [CoefW-1:0]           int_q, int_d, slp_q, slp_d;
  logic [FstatW-1:0]          fo_q, fo_d;
  logic                       su_q, su_d, fu_q, fu_d;
  logic [SampW-1:0]           n_q, n_d;

  // Register memory.
  logic [BigW-1:0] rf_mem [RegN];
  logic            rf_we;
  logic [BigW-1:0] rf_wdata;

  // Shared add/subtract unit and the sample multiplier.
  logic [BigW:0]              add_x, add_y, add_s;
  logic                       add_sub;
  logic signed [TraitW-1:0]   mul_a, mul_b;
  logic signed [2*TraitW-1:0] prod;

  instr_t                   cur;
  logic signed [MarkW-1:0]  x_in;
  logic                     used_in;
  logic                     adv;
  logic [BigW-1:0]          absv, res, rem_sh;
  logic signed [TraitW-1:0] x24;

  assign cur         = lrfs_prog(pc_q);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign x24         = TraitW'(x_q);

  assign add_s = add_x + (add_sub ? ~add_y : add_y) + (BigW + 1)'(add_sub);
  assign prod  = mul_a * mul_b;

  // Marker value: known genotype codes map to whole units, others take the imputed value.
  always_comb begin
    case (marker_code_i)
      4'sd1:   x_in = 18'sh10000;
      4'sd0:   x_in = '0;
      -4'sd1:  x_in = 18'sh30000;
      default: x_in = imputed_marker_i;
    endcase
  end

  assign used_in = (trait_value_i > thr_q) && (cnt_q < CntW'(MAX_SAMPLES));

  // Multiplier operand selection by accumulation step.
  always_comb begin
    case (state_q)
      S_M1:    begin mul_a = y_q; mul_b = y_q; end
      S_M2:    begin mul_a = x24; mul_b = x24; end
      default: begin mul_a = x24; mul_b = y_q; end
    endcase
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_d  = state_q;
    thr_d    = thr_q;
    cnt_d    = cnt_q;
    acc_y_d  = acc_y_q;
    acc_yy_d = acc_yy_q;
    acc_x_d  = acc_x_q;
    acc_xx_d = acc_xx_q;
    acc_xy_d = acc_xy_q;
    pc_d     = pc_q;
    ov_d     = ov_q;
    y_d      = y_q;
    x_d      = x_q;
    last_d   = last_q;
    use_d    = use_q;
    p_d      = p_q;
    ins_d    = ins_q;
    acc_d    = acc_q;
    m_d      = m_q;
    qr_d     = qr_q;
    neg_d    = neg_q;
    dz_d     = dz_q;
    lc_d     = lc_q;
    b1h_d    = b1h_q;
    b0h_d    = b0h_q;
    b0nh_d   = b0nh_q;
    fh_d     = fh_q;
    sxxbad_d = sxxbad_q;
    syyz_d   = syyz_q;
    dpos_d   = dpos_q;
    int_d    = int_q;
    slp_d    = slp_q;
    fo_d     = fo_q;
    su_d     = su_q;
    fu_d     = fu_q;
    n_d      = n_q;
    rf_we    = 1'b0;
    rf_wdata = '0;
    add_x    = '0;
    add_y    = '0;
    add_sub  = 1'b0;
    adv      = 1'b0;
    absv     = '0;
    res      = '0;
    rem_sh   = '0;

    if (cfg_valid_i) begin
      thr_d = cfg_data_i;
    end
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          y_d    = trait_value_i;
          x_d    = x_in;
          last_d = last_sample_i;
          use_d  = used_in;
          if (used_in) begin
            acc_y_d = acc_y_q + SyW'(trait_value_i);
            acc_x_d = acc_x_q + SxW'(x_in);
            cnt_d   = cnt_q + CntW'(1);
          end
          state_d = S_M1;
        end
      end
      S_M1: begin
        p_d     = prod;
        state_d = S_M2;
      end
      S_M2: begin
        if (use_q) begin
          acc_yy_d = acc_yy_q + SyyW'(p_q);
        end
        p_d     = prod;
        state_d = S_M3;
      end
      S_M3: begin
        if (use_q) begin
          acc_xx_d = acc_xx_q + SxxW'(p_q);
        end
        p_d     = prod;
        state_d = S_M4;
      end
      S_M4: begin
        if (use_q) begin
          acc_xy_d = acc_xy_q + SxyW'(p_q);
        end
        pc_d    = '0;
        state_d = last_q ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        ins_d   = cur;
        state_d = S_OP;
      end
      S_OP: begin
        case (ins_q.op)
          OP_LDA: begin
            rf_we = 1'b1;
            case (ins_q.imm)
              ACC_N:   rf_wdata = BigW'(cnt_q);
              ACC_SY:  rf_wdata = BigW'(acc_y_q);
              ACC_SX:  rf_wdata = BigW'(acc_x_q);
              ACC_SXX: rf_wdata = BigW'(acc_xx_q);
              ACC_SXY: rf_wdata = BigW'(acc_xy_q);
              default: rf_wdata = BigW'(acc_yy_q);
            endcase
            adv = 1'b1;
          end
          OP_LDI: begin
            rf_we    = 1'b1;
            rf_wdata = BigW'(ins_q.imm);
            adv      = 1'b1;
          end
          OP_SUB: begin
            add_x    = {1'b0, rda_q};
            add_y    = {1'b0, rdb_q};
            add_sub  = 1'b1;
            rf_we    = 1'b1;
            rf_wdata = add_s[BigW-1:0];
            adv      = 1'b1;
          end
          OP_SHL: begin
            rf_we    = 1'b1;
            rf_wdata = rda_q << ins_q.imm;
            adv      = 1'b1;
          end
          OP_OUT: begin
            case (ins_q.imm)
              OUT_B1:  b1h_d    = sat_s32(rda_q);
              OUT_B0:  b0h_d    = sat_s32(rda_q);
              OUT_B0N: b0nh_d   = sat_s32(rda_q);
              OUT_F:   fh_d     = sat_u48(rda_q);
              OUT_SXX: sxxbad_d = rda_q[BigW-1] || (rda_q == '0);
              OUT_SYY: syyz_d   = (rda_q == '0);
              default: dpos_d   = !rda_q[BigW-1] && (rda_q != '0);
            endcase
            adv = 1'b1;
          end
          OP_MUL, OP_DIV: begin
            state_d = S_ABSA;
          end
          default: begin
            adv = 1'b1;
          end
        endcase
      end
      // Magnitudes of both operands and the sign of the result.
      S_ABSA: begin
        add_y   = {1'b0, rda_q};
        add_sub = 1'b1;
        absv    = rda_q[BigW-1] ? add_s[BigW-1:0] : rda_q;
        if (ins_q.op == OP_MUL) begin
          m_d = absv;
        end else begin
          qr_d = absv;
        end
        neg_d   = rda_q[BigW-1] ^ rdb_q[BigW-1];
        state_d = S_ABSB;
      end
      S_ABSB: begin
        add_y   = {1'b0, rdb_q};
        add_sub = 1'b1;
        absv    = rdb_q[BigW-1] ? add_s[BigW-1:0] : rdb_q;
        if (ins_q.op == OP_MUL) begin
          qr_d = absv;
        end else begin
          m_d = absv;
        end
        dz_d    = (rdb_q == '0);
        acc_d   = '0;
        lc_d    = '0;
        state_d = S_LOOP;
      end
      // One bit of product or quotient a cycle.
      S_LOOP: begin
        if (ins_q.op == OP_MUL) begin
          if (qr_q == '0) begin
            state_d = S_FIX;
          end else begin
            add_x = {1'b0, acc_q};
            add_y = {1'b0, m_q};
            if (qr_q[0]) begin
              acc_d = add_s[BigW-1:0];
            end
            m_d  = m_q << 1;
            qr_d = qr_q >> 1;
          end
        end else begin
          rem_sh  = {acc_q[BigW-2:0], qr_q[BigW-1]};
          add_x   = {1'b0, rem_sh};
          add_y   = {1'b0, m_q};
          add_sub = 1'b1;
          if (!add_s[BigW]) begin
            acc_d = add_s[BigW-1:0];
            qr_d  = {qr_q[BigW-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            qr_d  = {qr_q[BigW-2:0], 1'b0};
          end
          lc_d = lc_q + LoopW'(1);
          if (lc_q == LoopW'(BigW - 1)) begin
            state_d = S_FIX;
          end
        end
      end
      // Restore the sign and write the result back.
      S_FIX: begin
        if (ins_q.op == OP_MUL) begin
          res = acc_q;
        end else begin
          res = dz_q ? '0 : qr_q;
        end
        add_y    = {1'b0, res};
        add_sub  = 1'b1;
        rf_we    = 1'b1;
        rf_wdata = neg_q ? add_s[BigW-1:0] : res;
        adv      = 1'b1;
      end
      // Hand the result to the output register and clear the sums.
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d  = 1'b1;
          su_d  = sxxbad_q;
          n_d   = SampW'(cnt_q);
          if (sxxbad_q) begin
            int_d = b0nh_q;
            slp_d = '0;
            fo_d  = '0;
            fu_d  = syyz_q;
          end else begin
            int_d = b0h_q;
            slp_d = b1h_q;
            fo_d  = dpos_q ? fh_q : '0;
            fu_d  = !dpos_q;
          end
          cnt_d    = '0;
          acc_y_d  = '0;
          acc_yy_d = '0;
          acc_x_d  = '0;
          acc_xx_d = '0;
          acc_xy_d = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Step the program counter after a finished operation.
    if (adv) begin
      if (pc_q == ProgLast) begin
        state_d = S_DONE;
      end else begin
        pc_d    = pc_q + PcW'(1);
        state_d = S_FETCH;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      thr_q    <= {1'b1, {(TraitW-1){1'b0}}};
      cnt_q    <= '0;
      acc_y_q  <= '0;
      acc_yy_q <= '0;
      acc_x_q  <= '0;
      acc_xx_q <= '0;
      acc_xy_q <= '0;
      pc_q     <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      thr_q    <= thr_d;
      cnt_q    <= cnt_d;
      acc_y_q  <= acc_y_d;
      acc_yy_q <= acc_yy_d;
      acc_x_q  <= acc_x_d;
      acc_xx_q <= acc_xx_d;
      acc_xy_q <= acc_xy_d;
      pc_q     <= pc_d;
      ov_q     <= ov_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    x_q      <= x_d;
    last_q   <= last_d;
    use_q    <= use_d;
    p_q      <= p_d;
    ins_q    <= ins_d;
    acc_q    <= acc_d;
    m_q      <= m_d;
    qr_q     <= qr_d;
    neg_q    <= neg_d;
    dz_q     <= dz_d;
    lc_q     <= lc_d;
    b1h_q    <= b1h_d;
    b0h_q    <= b0h_d;
    b0nh_q   <= b0nh_d;
    fh_q     <= fh_d;
    sxxbad_q <= sxxbad_d;
    syyz_q   <= syyz_d;
    dpos_q   <= dpos_d;
    int_q    <= int_d;
    slp_q    <= slp_d;
    fo_q     <= fo_d;
    su_q     <= su_d;
    fu_q     <= fu_d;
    n_q      <= n_d;
  end

  // Register memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[ins_q.dst] <= rf_wdata;
    end
    if (state_q == S_FETCH) begin
      rda_q <= rf_mem[cur.a];
      rdb_q <= rf_mem[cur.b];
    end
  end

  assign out_valid_o       = ov_q;
  assign intercept_o       = int_q;
  assign slope_o           = slp_q;
  assign f_statistic_o     = fo_q;
  assign slope_undefined_o = su_q;
  assign f_undefined_o     = fu_q;
  assign samples_used_o    = n_q;

endmodule

`default_nettype wire

/* sv/lrfs_checker.sv */
// Port-level assertions for the regression core, bound to the top level.
`default_nettype none

module lrfs_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic signed [lrfs_pkg::CoefW-1:0]   slope_o,
  input wire logic        [lrfs_pkg::FstatW-1:0]  f_statistic_o,
  input wire logic                                slope_undefined_o,
  input wire logic                                f_undefined_o,
  input wire logic        [lrfs_pkg::SampW-1:0]   samples_used_o
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Every accepted word keeps the input busy on the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not busy after an accepted word");

  // An undefined slope comes with a zero slope and a zero F.
  a_slope_undef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slope_undefined_o |-> (slope_o == '0) && (f_statistic_o == '0))
    else $error("undefined slope with nonzero slope or F");

  // An undefined F reads as zero.
  a_f_undef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && f_undefined_o |-> (f_statistic_o == '0))
    else $error("undefined F with nonzero value");

  // Fewer than two samples can never give a defined slope.
  a_few: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (samples_used_o < 13'd2) |-> slope_undefined_o)
    else $error("slope defined with fewer than two samples");

endmodule

bind linear_regression_f_stat_core lrfs_checker u_lrfs_checker (.*);

`default_nettype wire
